// File: hdl/mkwr_pkg.sv
// Shared types and constants for the multi-key wait registry.
// Holds operation and status codes, sequencer states and the result beat layout.
// No dependencies.
`default_nettype none

package mkwr_pkg;

  // Operation codes carried on operation_i
  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_ADD_KEY = 2'd1,
    OP_WAKE    = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  // Status codes carried on status_o
  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_NO_FREE     = 2'd1,
    STAT_NOT_IN_USE  = 2'd2,
    STAT_LIST_FULL   = 2'd3
  } status_e;

  // Sequencer states of the top level
  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_ADD,
    S_REL,
    S_WAKE,
    S_WEND
  } fsm_e;

  // Most result beats one wake may report
  localparam int MaxResults = 16;
  localparam int RepW       = 5;

  // One result beat
  typedef struct packed {
    status_e    status;
    logic [3:0] slot_out;
    logic       matched;
    logic       fired_valid;
    logic [3:0] fired_index;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/mkwr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the key store lanes. No dependencies.
`default_nettype none

module mkwr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one word, read one word into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/mkwr_row_match.sv
// Row compare unit: matches one key against all stored keys of one slot.
// Returns the lowest matching key index below the slot's key count. No dependencies.
`default_nettype none

module mkwr_row_match #(
  parameter int KEYS_PER_SLOT = 16,
  parameter int KEY_BITS      = 32
) (
  input  wire logic [KEYS_PER_SLOT-1:0][KEY_BITS-1:0]      row_i,
  input  wire logic [KEY_BITS-1:0]                         key_i,
  input  wire logic [$clog2(KEYS_PER_SLOT+1)-1:0]          count_i,
  output logic                                             hit_o,
  output logic [((KEYS_PER_SLOT > 1) ? $clog2(KEYS_PER_SLOT) : 1)-1:0] index_o
);

  localparam int KiW = (KEYS_PER_SLOT > 1) ? $clog2(KEYS_PER_SLOT) : 1;

  // Compare every lane, keep the lowest hit
  always_comb begin
    hit_o   = 1'b0;
    index_o = '0;
    for (int k = KEYS_PER_SLOT - 1; k >= 0; k--) begin
      if ((row_i[k] == key_i) && (k < int'(count_i))) begin
        hit_o   = 1'b1;
        index_o = KiW'(k);
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/multi_key_wait_registry.sv
// Multi-key wait registry: a table of WAITER_SLOTS waiter slots, each holding up to
// KEYS_PER_SLOT keys, driven by alloc, add-key, wake and release beats. One item is
// handled at a time; in_ready_o is high only while the sequencer is idle. Alloc walks the
// slot table one slot a cycle; wake reads one slot row of the key store a cycle, unless
// held while the output register cannot take a beat, and compares all its keys at once.
// Every item may also wait for the output register to drain. A wake returns one beat per
// matching slot (at most 16), or one beat with matched low; last_o marks the final beat
// of each item.
// Depends on mkwr_pkg, mkwr_ram and mkwr_row_match.
`default_nettype none

module multi_key_wait_registry #(
  parameter int WAITER_SLOTS  = 16,
  parameter int KEYS_PER_SLOT = 16,
  parameter int KEY_BITS      = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] operation_i,
  input  wire logic [3:0] slot_i,
  input  wire logic [31:0] key_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      status_o,
  output logic [3:0]      slot_out_o,
  output logic            matched_o,
  output logic            fired_valid_o,
  output logic [3:0]      fired_index_o,
  output logic            last_o
);

  import mkwr_pkg::*;

  localparam int SlotW = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
  localparam int KiW   = (KEYS_PER_SLOT > 1) ? $clog2(KEYS_PER_SLOT) : 1;
  localparam int KcW   = $clog2(KEYS_PER_SLOT + 1);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(WAITER_SLOTS - 1);

  // Sequencer and item registers
  fsm_e              state_q, state_d;
  op_e               op_in;
  logic [SlotW-1:0]  idx_q, idx_d;
  logic              bad_q, bad_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [SlotW-1:0]  rd_idx_q, rd_idx_d;
  logic              rd_done_q, rd_done_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic              pend_vld_q, pend_vld_d;
  logic [3:0]        pend_slot_q, pend_slot_d;
  logic [RepW-1:0]   rep_q, rep_d;

  // Slot table
  logic              in_use_q   [WAITER_SLOTS];
  logic [KcW-1:0]    key_count_q[WAITER_SLOTS];
  logic              fired_q    [WAITER_SLOTS];
  logic [KiW-1:0]    fidx_q     [WAITER_SLOTS];
  logic [4:0]        active_q;
  int                used_cnt;

  // Output register
  logic              out_vld_q;
  result_t           out_q;

  // Control strobes
  logic              can_push, push;
  result_t           push_res;
  logic              claim, add_wr, free_slot, fire, ram_re;
  logic              hit_now, report;

  // Key store lanes and compare unit
  logic [KEYS_PER_SLOT-1:0][KEY_BITS-1:0] row;
  logic              row_hit;
  logic [KiW-1:0]    row_index;
  logic [KcW-1:0]    cur_count;
  logic              cur_in_use;
  logic              cur_fired;
  logic [KiW-1:0]    cur_fidx;

  assign op_in      = op_e'(operation_i);
  assign cur_count  = key_count_q[idx_q];
  assign cur_in_use = in_use_q[idx_q];
  assign cur_fired  = fired_q[idx_q];
  assign cur_fidx   = fidx_q[idx_q];
  assign can_push   = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // One RAM per key index; a row read returns all keys of one slot
  for (genvar l = 0; l < KEYS_PER_SLOT; l++) begin : g_lane
    mkwr_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (WAITER_SLOTS)
    ) u_lane (
      .clk_i   (clk_i),
      .we_i    (add_wr && (int'(cur_count) == l)),
      .waddr_i (idx_q),
      .wdata_i (key_q),
      .re_i    (ram_re),
      .raddr_i (rd_idx_q),
      .rdata_o (row[l])
    );
  end

  mkwr_row_match #(
    .KEYS_PER_SLOT (KEYS_PER_SLOT),
    .KEY_BITS      (KEY_BITS)
  ) u_match (
    .row_i   (row),
    .key_i   (key_q),
    .count_i (cur_count),
    .hit_o   (row_hit),
    .index_o (row_index)
  );

  assign hit_now = cmp_vld_q && cur_in_use && row_hit;
  assign report  = hit_now && (rep_q < RepW'(MaxResults));

  // Next state and strobes
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    bad_d       = bad_q;
    key_d       = key_q;
    rd_idx_d    = rd_idx_q;
    rd_done_d   = rd_done_q;
    cmp_vld_d   = cmp_vld_q;
    pend_vld_d  = pend_vld_q;
    pend_slot_d = pend_slot_q;
    rep_d       = rep_q;
    push        = 1'b0;
    push_res    = '0;
    claim       = 1'b0;
    add_wr      = 1'b0;
    free_slot   = 1'b0;
    fire        = 1'b0;
    ram_re      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          idx_d       = (op_in == OP_ALLOC) ? '0 : SlotW'(slot_i);
          bad_d       = (int'(slot_i) >= WAITER_SLOTS);
          key_d       = KEY_BITS'({32'd0, key_i});
          rd_idx_d    = '0;
          rd_done_d   = 1'b0;
          cmp_vld_d   = 1'b0;
          pend_vld_d  = 1'b0;
          rep_d       = '0;
          case (op_in)
            OP_ALLOC:   state_d = S_ALLOC;
            OP_ADD_KEY: state_d = S_ADD;
            OP_WAKE:    state_d = S_WAKE;
            default:    state_d = S_REL;
          endcase
        end
      end
      S_ALLOC: begin
        // Walk the table for the lowest free slot
        if (!cur_in_use) begin
          if (can_push) begin
            claim             = 1'b1;
            push              = 1'b1;
            push_res.status   = STAT_OK;
            push_res.slot_out = 4'(idx_q);
            push_res.last     = 1'b1;
            state_d           = S_IDLE;
          end
        end else if (idx_q == LastSlot) begin
          if (can_push) begin
            push            = 1'b1;
            push_res.status = STAT_NO_FREE;
            push_res.last   = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_ADD: begin
        if (can_push) begin
          push          = 1'b1;
          push_res.last = 1'b1;
          state_d       = S_IDLE;
          if (bad_q || !cur_in_use) begin
            push_res.status = STAT_NOT_IN_USE;
          end else if (int'(cur_count) >= KEYS_PER_SLOT) begin
            push_res.status = STAT_LIST_FULL;
          end else begin
            push_res.status = STAT_OK;
            add_wr          = 1'b1;
          end
        end
      end
      S_REL: begin
        if (can_push) begin
          push          = 1'b1;
          push_res.last = 1'b1;
          state_d       = S_IDLE;
          if (bad_q) begin
            push_res.status = STAT_NOT_IN_USE;
          end else begin
            push_res.fired_valid = cur_fired;
            push_res.fired_index = cur_fired ? 4'(cur_fidx) : 4'd0;
            if (!cur_in_use) begin
              push_res.status = STAT_NOT_IN_USE;
            end else begin
              push_res.status = STAT_OK;
              free_slot       = 1'b1;
            end
          end
        end
      end
      S_WAKE: begin
        // Hold the scan while a reported match cannot hand its predecessor over
        if (!(report && pend_vld_q && !can_push)) begin
          if (!rd_done_q) begin
            ram_re    = 1'b1;
            idx_d     = rd_idx_q;
            cmp_vld_d = 1'b1;
            rd_done_d = (rd_idx_q == LastSlot);
            rd_idx_d  = rd_idx_q + 1'b1;
          end else begin
            cmp_vld_d = 1'b0;
          end
          if (hit_now && !cur_fired) begin
            fire = 1'b1;
          end
          if (report) begin
            if (pend_vld_q) begin
              push              = 1'b1;
              push_res.status   = STAT_OK;
              push_res.slot_out = pend_slot_q;
              push_res.matched  = 1'b1;
            end
            pend_vld_d  = 1'b1;
            pend_slot_d = 4'(idx_q);
            rep_d       = rep_q + 1'b1;
          end
          if (cmp_vld_q && (idx_q == LastSlot)) begin
            state_d = S_WEND;
          end
        end
      end
      S_WEND: begin
        // Flush the held match as the final beat, or report no match
        if (can_push) begin
          push              = 1'b1;
          push_res.status   = STAT_OK;
          push_res.slot_out = pend_vld_q ? pend_slot_q : 4'd0;
          push_res.matched  = pend_vld_q;
          push_res.last     = 1'b1;
          pend_vld_d        = 1'b0;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      rd_done_q  <= 1'b0;
      cmp_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      rep_q      <= '0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      rd_done_q  <= rd_done_d;
      cmp_vld_q  <= cmp_vld_d;
      pend_vld_q <= pend_vld_d;
      rep_q      <= rep_d;
    end
  end

  // Item payload registers
  always_ff @(posedge clk_i) begin
    bad_q       <= bad_d;
    key_q       <= key_d;
    rd_idx_q    <= rd_idx_d;
    pend_slot_q <= pend_slot_d;
  end

  // Slot table updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < WAITER_SLOTS; s++) begin
        in_use_q[s]    <= 1'b0;
        key_count_q[s] <= '0;
        fired_q[s]     <= 1'b0;
        fidx_q[s]      <= '0;
      end
      active_q <= '0;
    end else begin
      if (claim) begin
        in_use_q[idx_q]    <= 1'b1;
        key_count_q[idx_q] <= '0;
        fired_q[idx_q]     <= 1'b0;
        fidx_q[idx_q]      <= '0;
        active_q           <= active_q + 5'd1;
      end
      if (add_wr) begin
        key_count_q[idx_q] <= cur_count + 1'b1;
      end
      if (free_slot) begin
        in_use_q[idx_q]    <= 1'b0;
        key_count_q[idx_q] <= '0;
        if (active_q != 5'd0) begin
          active_q <= active_q - 5'd1;
        end
      end
      if (fire) begin
        fired_q[idx_q] <= 1'b1;
        fidx_q[idx_q]  <= row_index;
      end
    end
  end

  // Output register: load a new beat, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (push) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= push_res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_q.status;
  assign slot_out_o    = out_q.slot_out;
  assign matched_o     = out_q.matched;
  assign fired_valid_o = out_q.fired_valid;
  assign fired_index_o = out_q.fired_index;
  assign last_o        = out_q.last;

  // Count claimed slots for the consistency check
  always_comb begin
    used_cnt = 0;
    for (int s = 0; s < WAITER_SLOTS; s++) begin
      used_cnt = used_cnt + int'(in_use_q[s]);
    end
  end

  // A held wake match never outlives its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_vld_q)
    else $error("wake match left pending at idle");

  // Reported beats of one wake stay within the cap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_q <= RepW'(MaxResults))
    else $error("wake reported too many beats");

  // A key list never grows past its capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cur_count) <= KEYS_PER_SLOT)
    else $error("key count above capacity");

  // Active count tracks claimed slots while it cannot wrap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (WAITER_SLOTS < 32) |-> (int'(active_q) == used_cnt))
    else $error("active count out of step with slot table");

endmodule

`default_nettype wire

// File: tb/tb_multi_key_wait_registry.sv
// Self-checking testbench for multi_key_wait_registry: queued commands are driven on
// a valid/ready channel and every result beat is checked against an in-bench registry.
// Depends on mkwr_pkg and the multi_key_wait_registry RTL.
`timescale 1ns / 1ps

module tb_multi_key_wait_registry;
  import mkwr_pkg::*;

  localparam int NSlots   = 16;
  localparam int NKeys    = 16;
  localparam int RandCmds = 300;

  typedef struct packed {
    op_e         op;
    logic [3:0]  slot;
    logic [31:0] key;
    logic        drain;
  } cmd_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [1:0]  operation   = 2'd0;
  logic [3:0]  slot_in     = 4'd0;
  logic [31:0] key_in      = 32'd0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [1:0]  status_out;
  logic [3:0]  slot_out;
  logic        matched;
  logic        fired_valid;
  logic [3:0]  fired_index;
  logic        last;

  multi_key_wait_registry dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .operation_i   (operation),
    .slot_i        (slot_in),
    .key_i         (key_in),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status_out),
    .slot_out_o    (slot_out),
    .matched_o     (matched),
    .fired_valid_o (fired_valid),
    .fired_index_o (fired_index),
    .last_o        (last)
  );

  // Commands waiting to be driven, result beats waiting to arrive
  cmd_t    cmd_q[$];
  result_t due_beats[$];
  int      errors = 0;
  int      n_in   = 0;
  logic    in_took = 1'b0;

  // Registry mirror used for checking
  logic        busy      [NSlots];
  logic [4:0]  nkeys     [NSlots];
  logic        fired     [NSlots];
  logic [3:0]  fired_idx [NSlots];
  logic [31:0] keys      [NSlots][NKeys];
  logic [4:0]  live_count;

  // Slot occupancy as seen while the command list is built
  logic        plan_used [NSlots];
  int          plan_cnt  [NSlots];
  logic [31:0] key_pool  [8];
  logic        drain_next;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Apply one command to the mirror and queue the beats it must produce
  task automatic apply_to_registry(input cmd_t c);
    result_t r;
    int      n;
    bit      hit;
    bit      found;
    r = '0;
    r.last = 1'b1;
    case (c.op)
      OP_ALLOC: begin
        found = 1'b0;
        r.status = STAT_NO_FREE;
        for (int i = 0; i < NSlots; i++) begin
          if (!found && !busy[i]) begin
            found = 1'b1;
            busy[i] = 1'b1;
            nkeys[i] = '0;
            fired[i] = 1'b0;
            fired_idx[i] = '0;
            live_count = live_count + 5'd1;
            r.status = STAT_OK;
            r.slot_out = i[3:0];
          end
        end
        due_beats.push_back(r);
      end
      OP_ADD_KEY: begin
        if (!busy[c.slot]) begin
          r.status = STAT_NOT_IN_USE;
        end else if (nkeys[c.slot] >= NKeys) begin
          r.status = STAT_LIST_FULL;
        end else begin
          keys[c.slot][nkeys[c.slot][3:0]] = c.key;
          nkeys[c.slot] = nkeys[c.slot] + 5'd1;
          r.status = STAT_OK;
        end
        due_beats.push_back(r);
      end
      OP_WAKE: begin
        n = 0;
        for (int i = 0; i < NSlots; i++) begin
          if (busy[i]) begin
            hit = 1'b0;
            for (int k = 0; k < NKeys; k++) begin
              if (!hit && k < nkeys[i] && keys[i][k] == c.key) begin
                hit = 1'b1;
                // only the first wake records an index
                if (!fired[i]) begin
                  fired[i] = 1'b1;
                  fired_idx[i] = k[3:0];
                end
              end
            end
            if (hit && n < MaxResults) begin
              r = '0;
              r.status = STAT_OK;
              r.slot_out = i[3:0];
              r.matched = 1'b1;
              due_beats.push_back(r);
              n++;
            end
          end
        end
        if (n == 0) begin
          r = '0;
          r.status = STAT_OK;
          r.last = 1'b1;
        end else begin
          r = due_beats.pop_back();
          r.last = 1'b1;
        end
        due_beats.push_back(r);
      end
      default: begin
        // release reports the mark even on a free slot and never clears it
        r.fired_valid = fired[c.slot];
        r.fired_index = fired[c.slot] ? fired_idx[c.slot] : 4'd0;
        if (!busy[c.slot]) begin
          r.status = STAT_NOT_IN_USE;
        end else begin
          r.status = STAT_OK;
          busy[c.slot] = 1'b0;
          nkeys[c.slot] = '0;
          if (live_count != 0) live_count = live_count - 5'd1;
        end
        due_beats.push_back(r);
      end
    endcase
  endtask

  // Queue a command and track slot occupancy for later commands
  task automatic push_cmd(input op_e op, input int slot, input logic [31:0] key);
    cmd_t c;
    bit   found;
    c.op = op;
    c.slot = slot[3:0];
    c.key = key;
    c.drain = drain_next;
    drain_next = 1'b0;
    cmd_q.push_back(c);
    case (op)
      OP_ALLOC: begin
        found = 1'b0;
        for (int i = 0; i < NSlots; i++) begin
          if (!found && !plan_used[i]) begin
            found = 1'b1;
            plan_used[i] = 1'b1;
            plan_cnt[i] = 0;
          end
        end
      end
      OP_ADD_KEY: if (plan_used[slot] && plan_cnt[slot] < NKeys) plan_cnt[slot]++;
      OP_RELEASE: plan_used[slot] = 1'b0;
      default: ;
    endcase
  endtask

  // Mostly keys from a small pool so that wakes find matches
  function automatic logic [31:0] pick_key();
    if ($urandom_range(7) == 0) return $urandom;
    return key_pool[$urandom_range(7)];
  endfunction

  // Random claimed slot, or -1 if none is claimed
  function automatic int pick_used_slot();
    int picks[$];
    for (int i = 0; i < NSlots; i++) if (plan_used[i]) picks.push_back(i);
    if (picks.size() == 0) return -1;
    return picks[$urandom_range(picks.size() - 1)];
  endfunction

  function automatic int first_free_slot();
    for (int i = 0; i < NSlots; i++) if (!plan_used[i]) return i;
    return -1;
  endfunction

  // Build the command list, then wait for the run to drain
  initial begin
    int n_rand;
    int pick;
    int s;
    int cnt;
    logic [31:0] k;

    drain_next = 1'b0;
    live_count = '0;
    for (int i = 0; i < NSlots; i++) begin
      busy[i] = 1'b0;
      nkeys[i] = '0;
      fired[i] = 1'b0;
      fired_idx[i] = '0;
      plan_used[i] = 1'b0;
      plan_cnt[i] = 0;
    end
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;

    // Directed: free-slot errors, empty wake, shared keys, refire, mark kept on release
    push_cmd(OP_RELEASE, 0, 32'h0);
    push_cmd(OP_ADD_KEY, 5, 32'hFFFF_FFFF);
    push_cmd(OP_WAKE, 0, 32'h0);
    push_cmd(OP_ALLOC, 0, 32'h0);
    push_cmd(OP_ALLOC, 15, 32'h0);
    push_cmd(OP_ADD_KEY, 0, 32'h0000_0000);
    push_cmd(OP_ADD_KEY, 0, 32'hFFFF_FFFF);
    push_cmd(OP_ADD_KEY, 0, 32'hA5A5_A5A5);
    push_cmd(OP_ADD_KEY, 1, 32'hFFFF_FFFF);
    push_cmd(OP_ADD_KEY, 1, 32'h5A5A_5A5A);
    push_cmd(OP_WAKE, 15, 32'hFFFF_FFFF);
    push_cmd(OP_WAKE, 0, 32'h0000_0000);
    push_cmd(OP_WAKE, 0, 32'h1234_5678);
    push_cmd(OP_RELEASE, 0, 32'hFFFF_FFFF);
    push_cmd(OP_RELEASE, 0, 32'h0);
    push_cmd(OP_RELEASE, 15, 32'h0);
    push_cmd(OP_ADD_KEY, 15, 32'h0);
    push_cmd(OP_ALLOC, 0, 32'hFFFF_FFFF);
    push_cmd(OP_RELEASE, 0, 32'h0);
    push_cmd(OP_RELEASE, 1, 32'h0);

    // Random: mostly well-formed sequences, some noise
    n_rand = 0;
    drain_next = 1'b1;
    while (n_rand < RandCmds) begin
      pick = $urandom_range(99);
      if (pick < 26) begin
        // claim a slot and give it a few keys
        s = first_free_slot();
        push_cmd(OP_ALLOC, $urandom_range(15), $urandom);
        n_rand++;
        if (s >= 0) begin
          cnt = $urandom_range(1, 4);
          for (int j = 0; j < cnt; j++) push_cmd(OP_ADD_KEY, s, pick_key());
          n_rand += cnt;
        end
      end else if (pick < 50) begin
        push_cmd(OP_WAKE, $urandom_range(15), pick_key());
        n_rand++;
      end else if (pick < 70) begin
        s = pick_used_slot();
        push_cmd(OP_RELEASE, (s < 0) ? $urandom_range(15) : s, $urandom);
        n_rand++;
      end else if (pick < 84) begin
        push_cmd(op_e'($urandom_range(3)), $urandom_range(15), $urandom);
        n_rand++;
      end else if (pick < 89) begin
        // fill one key list and overrun it
        s = pick_used_slot();
        if (s >= 0) begin
          while (plan_cnt[s] < NKeys) begin
            push_cmd(OP_ADD_KEY, s, pick_key());
            n_rand++;
          end
          push_cmd(OP_ADD_KEY, s, $urandom);
          n_rand++;
        end
      end else if (pick < 93) begin
        // claim every slot and one more
        while (first_free_slot() >= 0) begin
          push_cmd(OP_ALLOC, $urandom_range(15), $urandom);
          n_rand++;
        end
        push_cmd(OP_ALLOC, $urandom_range(15), $urandom);
        n_rand++;
      end else begin
        // share one key across all claimed slots with room left, then wake it
        k = pick_key();
        for (int i = 0; i < NSlots; i++) begin
          if (plan_used[i] && plan_cnt[i] < NKeys) begin
            push_cmd(OP_ADD_KEY, i, k);
            n_rand++;
          end
        end
        push_cmd(OP_WAKE, $urandom_range(15), k);
        n_rand++;
      end
      if (n_rand >= 100 && n_rand < 110) drain_next = 1'b1;
    end

    // Hold reset, then release it away from the rising edge
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for stimulus and results to drain
    while (cmd_q.size() != 0 || in_valid) @(posedge clk_i);
    while (due_beats.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("[multi_key_wait_registry] OK");
    end else begin
      $display("[multi_key_wait_registry] ERROR");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #2_000_000;
    $display("[multi_key_wait_registry] ERROR");
    $finish;
  end

  // Drive command beats on the falling edge
  int tx_count = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold the beat until it is taken
    end else if (cmd_q.size() == 0) begin
      in_valid <= 1'b0;
    end else if (cmd_q[0].drain && due_beats.size() != 0) begin
      in_valid <= 1'b0;
    end else if (!(tx_count >= 150 && tx_count < 200) && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
    end else begin
      operation <= cmd_q[0].op;
      slot_in   <= cmd_q[0].slot;
      key_in    <= cmd_q[0].key;
      in_valid  <= 1'b1;
      void'(cmd_q.pop_front());
      tx_count <= tx_count + 1;
    end
  end

  // Result-side ready: one long hold-off, a steady stretch, random stalls elsewhere
  int  hold_left = 0;
  logic hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (!hold_done && n_in >= 120) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (n_in >= 200 && n_in < 260) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 25);
    end
  end

  // Check result beats, then record accepted commands
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    cmd_t    c;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        got.status      = status_e'(status_out);
        got.slot_out    = slot_out;
        got.matched     = matched;
        got.fired_valid = fired_valid;
        got.fired_index = fired_index;
        got.last        = last;
        if (due_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat st=%0d slot=%0d m=%0d fv=%0d fi=%0d last=%0d",
                   $time, got.status, got.slot_out, got.matched, got.fired_valid,
                   got.fired_index, got.last);
        end else begin
          want = due_beats.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected st=%0d slot=%0d m=%0d fv=%0d fi=%0d last=%0d",
                     $time, want.status, want.slot_out, want.matched, want.fired_valid,
                     want.fired_index, want.last);
            $display("%0t:          actual   st=%0d slot=%0d m=%0d fv=%0d fi=%0d last=%0d",
                     $time, got.status, got.slot_out, got.matched, got.fired_valid,
                     got.fired_index, got.last);
          end
        end
      end
      if (in_valid && in_ready) begin
        c.op    = op_e'(operation);
        c.slot  = slot_in;
        c.key   = key_in;
        c.drain = 1'b0;
        apply_to_registry(c);
        n_in <= n_in + 1;
      end
    end
    in_took <= in_valid && in_ready && rst_ni;
  end

endmodule
